// ===== sv/ipv_pkg.sv =====
package ipv_pkg;

  // Default path length limit; offsets saturate one below it (at most 16 bits)
  localparam int unsigned MaxPathBytesDef = 65536;

  localparam int unsigned OffsetW = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CodeW   = 4;

  // Verdict codes
  typedef enum logic [CodeW-1:0] {
    ERR_OK          = 4'd0,
    ERR_EMPTY       = 4'd1,
    ERR_LEAD_SPACE  = 4'd2,
    ERR_ABSOLUTE    = 4'd3,
    ERR_SELF        = 4'd4,
    ERR_BAD_DOT     = 4'd5,
    ERR_TRAIL_SPACE = 4'd6,
    ERR_AT_SIGN     = 4'd7,
    ERR_BACKSLASH   = 4'd8,
    ERR_INVALID     = 4'd9,
    ERR_PARENT_REF  = 4'd10
  } err_e;

  // Characters of interest
  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChSlash = 8'h2F;
  localparam logic [ByteW-1:0] ChDot   = 8'h2E;
  localparam logic [ByteW-1:0] ChAt    = 8'h40;
  localparam logic [ByteW-1:0] ChColon = 8'h3A;
  localparam logic [ByteW-1:0] ChBslash = 8'h5C;

endpackage

// ===== sv/import_path_validator_core.sv =====
// The verdict reaches the master side in the cycle after the transaction that ends
//   a path (tlast or empty tuser).
// Throughput: one path byte per cycle unless a verdict waits; the result register sits
//   between the two sides, so a new byte is taken in the cycle a pending verdict is drained.
// Reset: rst_ni clears the path state and the result valid; the first byte after
//   reset is treated as the start of a path.
module import_path_validator_core
  import ipv_pkg::*;
#(
  parameter int unsigned MAX_PATH_BYTES = MaxPathBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] path_byte
  input  logic        s_axis_tlast,   // final_byte
  input  logic        s_axis_tuser,   // empty_path
  // master side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [3:0] error_code, [19:4] error_offset, [23:20] zero
);

  localparam int unsigned OffsetMaxInt =
    (MAX_PATH_BYTES - 1 < 65535) ? (MAX_PATH_BYTES - 1) : 65535;
  localparam logic [OffsetW-1:0] OffsetMax = OffsetW'(OffsetMaxInt);

  // Path state
  logic [OffsetW-1:0]  byte_pos_q, byte_pos_d;
  logic [3*ByteW-1:0]  recent_q, recent_d;
  logic                lead_dot_q, lead_dot_d;
  err_e                prefix_q, prefix_d;
  err_e                cf_code_q, cf_code_d;
  logic [OffsetW-1:0]  cf_off_q, cf_off_d;
  logic                pr_found_q, pr_found_d;
  logic [OffsetW-1:0]  pr_off_q, pr_off_d;

  // Result register
  logic                m_valid_q, m_valid_d;
  err_e                res_code_q, res_code_d;
  logic [OffsetW-1:0]  res_off_q, res_off_d;

  logic               s_fire;
  logic               done;
  logic [ByteW-1:0]   b, b1, b2, b3;
  logic [OffsetW-1:0] pos;
  logic [OffsetW-1:0] pos_back1, pos_back2;
  err_e               char_code;

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign done          = s_axis_tlast || s_axis_tuser;

  assign b   = s_axis_tdata;
  assign b1  = recent_q[ByteW-1:0];
  assign b2  = recent_q[2*ByteW-1:ByteW];
  assign b3  = recent_q[3*ByteW-1:2*ByteW];
  assign pos = byte_pos_q;

  // Offset one or two bytes back; saturated or underflowing positions report the max
  assign pos_back1 = (pos >= OffsetMax || pos < OffsetW'(1)) ? OffsetMax : pos - OffsetW'(1);
  assign pos_back2 = (pos >= OffsetMax || pos < OffsetW'(2)) ? OffsetMax : pos - OffsetW'(2);

  // Classify the current byte as a forbidden character
  always_comb begin
    char_code = ERR_OK;
    if (b == ChSpace) begin
      char_code = s_axis_tlast ? ERR_TRAIL_SPACE : ERR_OK;
    end else if (b == ChAt) begin
      char_code = ERR_AT_SIGN;
    end else if (b == ChBslash) begin
      char_code = ERR_BACKSLASH;
    end else if (b < ChSpace || b == ChColon) begin
      char_code = ERR_INVALID;
    end
  end

  // Update the path state and form the verdict
  always_comb begin
    byte_pos_d = byte_pos_q;
    recent_d   = recent_q;
    lead_dot_d = lead_dot_q;
    prefix_d   = prefix_q;
    cf_code_d  = cf_code_q;
    cf_off_d   = cf_off_q;
    pr_found_d = pr_found_q;
    pr_off_d   = pr_off_q;
    m_valid_d  = m_valid_q;
    res_code_d = res_code_q;
    res_off_d  = res_off_q;

    // drain the result register
    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    if (s_fire) begin
      // first-byte checks
      if (pos == '0) begin
        if (b == ChSpace) begin
          prefix_d = ERR_LEAD_SPACE;
        end else if (b == ChSlash) begin
          prefix_d = ERR_ABSOLUTE;
        end else if (b == ChDot) begin
          lead_dot_d = 1'b1;
          if (s_axis_tlast) prefix_d = ERR_SELF;
        end
      end else if (lead_dot_q && prefix_q == ERR_OK) begin
        if (pos == OffsetW'(1)) begin
          if (b == ChDot) begin
            if (s_axis_tlast) prefix_d = ERR_BAD_DOT;
          end else if (b != ChSlash) begin
            prefix_d = ERR_BAD_DOT;
          end
        end else if (pos == OffsetW'(2) && b1 == ChDot && b != ChSlash) begin
          prefix_d = ERR_BAD_DOT;
        end
      end

      // first forbidden byte
      if (cf_code_q == ERR_OK && char_code != ERR_OK) begin
        cf_code_d = char_code;
        cf_off_d  = pos;
      end

      // first slash-dot-dot-slash
      if (!pr_found_q && b == ChSlash && b1 == ChDot && b2 == ChDot && b3 == ChSlash) begin
        pr_found_d = 1'b1;
        pr_off_d   = pos_back2;
      end

      recent_d = {recent_q[2*ByteW-1:0], b};
      if (byte_pos_q < OffsetMax) begin
        byte_pos_d = byte_pos_q + OffsetW'(1);
      end

      // verdict in priority order
      if (done) begin
        m_valid_d  = 1'b1;
        res_code_d = ERR_OK;
        res_off_d  = '0;
        if (s_axis_tuser) begin
          res_code_d = ERR_EMPTY;
        end else if (prefix_d != ERR_OK) begin
          res_code_d = prefix_d;
          res_off_d  = (prefix_d == ERR_BAD_DOT) ? OffsetW'(1) : '0;
        end else if (cf_code_d != ERR_OK) begin
          res_code_d = cf_code_d;
          res_off_d  = cf_off_d;
        end else if (!lead_dot_d) begin
          if (pr_found_d) begin
            res_code_d = ERR_PARENT_REF;
            res_off_d  = pr_off_d;
          end else if (b == ChDot && b1 == ChDot && b2 == ChSlash) begin
            res_code_d = ERR_PARENT_REF;
            res_off_d  = pos_back1;
          end
        end

        // clear for the next path
        byte_pos_d = '0;
        recent_d   = '0;
        lead_dot_d = 1'b0;
        prefix_d   = ERR_OK;
        cf_code_d  = ERR_OK;
        cf_off_d   = '0;
        pr_found_d = 1'b0;
        pr_off_d   = '0;
      end
    end
  end

  // Control and path state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q <= '0;
      recent_q   <= '0;
      lead_dot_q <= 1'b0;
      prefix_q   <= ERR_OK;
      cf_code_q  <= ERR_OK;
      cf_off_q   <= '0;
      pr_found_q <= 1'b0;
      pr_off_q   <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      byte_pos_q <= byte_pos_d;
      recent_q   <= recent_d;
      lead_dot_q <= lead_dot_d;
      prefix_q   <= prefix_d;
      cf_code_q  <= cf_code_d;
      cf_off_q   <= cf_off_d;
      pr_found_q <= pr_found_d;
      pr_off_q   <= pr_off_d;
      m_valid_q  <= m_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    res_code_q <= res_code_d;
    res_off_q  <= res_off_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0000, res_off_q, res_code_q};

  // An ending transaction always yields a verdict in the next cycle
  a_done_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && done |=> m_axis_tvalid)
    else $error("verdict missing after end of path");

  // An empty path reports the empty code with zero offset
  a_empty_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && s_axis_tuser |=> res_code_q == ERR_EMPTY && res_off_q == '0)
    else $error("empty path verdict wrong");

  // State is cleared after every verdict
  a_state_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && done |=> byte_pos_q == '0 && !pr_found_q && cf_code_q == ERR_OK)
    else $error("path state not cleared");

  // Position never passes its saturation point
  a_pos_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_pos_q <= OffsetMax)
    else $error("byte position beyond saturation");

  // A leading dot forbids any later parent-reference verdict in the same path
  a_dot_no_parent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && s_axis_tlast && !s_axis_tuser && lead_dot_q |=> res_code_q != ERR_PARENT_REF)
    else $error("parent reference on dot-prefixed path");

endmodule

// ===== tb/sv/testbench.sv =====
module testbench
  import ipv_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned OffMaxInt =
    (MaxPathBytesDef - 1 < 65535) ? MaxPathBytesDef - 1 : 65535;
  localparam logic [OffsetW-1:0] OffMax = OffsetW'(OffMaxInt);
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned FeedItems = 1450;
  localparam int unsigned MaxReports = 100;

  typedef struct packed {
    logic [ByteW-1:0] path_char;
    logic             last_flag;
    logic             empty_flag;
  } path_item_t;

  typedef struct packed {
    err_e               code;
    logic [OffsetW-1:0] offset;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  // Stimulus feed, expected verdicts, bookkeeping
  path_item_t  byte_feed[$];
  verdict_t    verdict_q[$];
  int unsigned total_items;
  int unsigned items_taken = 0;
  int unsigned fail_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned cyc_count = 0;
  logic        in_taken = 1'b0;
  logic        calm;

  // Path tracking state of the predictor
  logic [OffsetW-1:0] trk_pos;
  logic [23:0]        trk_tail;
  logic               trk_dot_lead;
  err_e               trk_prefix;
  err_e               trk_char_code;
  logic [OffsetW-1:0] trk_char_off;
  logic               trk_parent_hit;
  logic [OffsetW-1:0] trk_parent_off;

  import_path_validator_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] path_byte
    .s_axis_tlast  (s_axis_tlast),   // final_byte
    .s_axis_tuser  (s_axis_tuser),   // empty_path
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)    // [3:0] error_code, [19:4] error_offset, [23:20] zero
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Idle-free stretch that recurs in every window of the cycle counter
  assign calm = ((cyc_count % 2000) >= 600) && ((cyc_count % 2000) < 1000);

  function automatic void note_fail(input string msg);
    if (fail_count < MaxReports) $error("%s", msg);
    fail_count++;
  endfunction

  function automatic logic [OffsetW-1:0] back_off(input logic [OffsetW-1:0] pos,
                                                  input int unsigned k);
    if (pos >= OffMax || pos < k) return OffMax;
    return pos - OffsetW'(k);
  endfunction

  function automatic void clear_path_track();
    trk_pos        = '0;
    trk_tail       = '0;
    trk_dot_lead   = 1'b0;
    trk_prefix     = ERR_OK;
    trk_char_code  = ERR_OK;
    trk_char_off   = '0;
    trk_parent_hit = 1'b0;
    trk_parent_off = '0;
  endfunction

  // Advance the path state by one transaction; queue a verdict when the path ends
  function automatic void track_path_byte(input path_item_t it);
    logic [7:0]         b, b1, b2, b3;
    logic [OffsetW-1:0] pos, off;
    err_e               code, fault;
    verdict_t           v;
    if (it.empty_flag) begin
      v.code   = ERR_EMPTY;
      v.offset = '0;
      verdict_q.push_back(v);
      clear_path_track();
    end else begin
      b   = it.path_char;
      pos = trk_pos;
      b1  = trk_tail[7:0];
      b2  = trk_tail[15:8];
      b3  = trk_tail[23:16];

      // first-byte and dot-prefix checks
      if (pos == 0) begin
        if (b == ChSpace) trk_prefix = ERR_LEAD_SPACE;
        else if (b == ChSlash) trk_prefix = ERR_ABSOLUTE;
        else if (b == ChDot) begin
          trk_dot_lead = 1'b1;
          if (it.last_flag) trk_prefix = ERR_SELF;
        end
      end else if (trk_dot_lead && trk_prefix == ERR_OK) begin
        if (pos == 1) begin
          if (b == ChDot) begin
            if (it.last_flag) trk_prefix = ERR_BAD_DOT;
          end else if (b != ChSlash) begin
            trk_prefix = ERR_BAD_DOT;
          end
        end else if (pos == 2 && b1 == ChDot && b != ChSlash) begin
          trk_prefix = ERR_BAD_DOT;
        end
      end

      // first forbidden byte
      fault = ERR_OK;
      if (b == ChSpace) begin
        if (it.last_flag) fault = ERR_TRAIL_SPACE;
      end else if (b == ChAt) fault = ERR_AT_SIGN;
      else if (b == ChBslash) fault = ERR_BACKSLASH;
      else if (b < ChSpace || b == ChColon) fault = ERR_INVALID;
      if (trk_char_code == ERR_OK && fault != ERR_OK) begin
        trk_char_code = fault;
        trk_char_off  = pos;
      end

      // first interior parent reference
      if (!trk_parent_hit && b == ChSlash && b1 == ChDot && b2 == ChDot && b3 == ChSlash) begin
        trk_parent_hit = 1'b1;
        trk_parent_off = back_off(pos, 2);
      end

      trk_tail = {trk_tail[15:0], b};
      if (trk_pos < OffMax) trk_pos++;

      if (it.last_flag) begin
        code = ERR_OK;
        off  = '0;
        if (trk_prefix != ERR_OK) begin
          code = trk_prefix;
          off  = (trk_prefix == ERR_BAD_DOT) ? OffsetW'(1) : '0;
        end else if (trk_char_code != ERR_OK) begin
          code = trk_char_code;
          off  = trk_char_off;
        end else if (!trk_dot_lead) begin
          if (trk_parent_hit) begin
            code = ERR_PARENT_REF;
            off  = trk_parent_off;
          end else if (b == ChDot && b1 == ChDot && b2 == ChSlash) begin
            code = ERR_PARENT_REF;
            off  = back_off(pos, 1);
          end
        end
        v.code   = code;
        v.offset = off;
        verdict_q.push_back(v);
        clear_path_track();
      end
    end
  endfunction

  // Stimulus building
  function automatic void add_text(ref logic [7:0] chars[$], input string s);
    for (int i = 0; i < s.len(); i++) chars.push_back(s[i]);
  endfunction

  function automatic void push_empty();
    path_item_t it;
    it.path_char  = 8'($urandom_range(255));
    it.last_flag  = 1'($urandom_range(1));
    it.empty_flag = 1'b1;
    byte_feed.push_back(it);
  endfunction

  // Queue a path; an aborted path loses its end marker and is cut by an empty transaction
  function automatic void queue_path(ref logic [7:0] chars[$], input logic abort);
    path_item_t it;
    for (int i = 0; i < chars.size(); i++) begin
      it.path_char  = chars[i];
      it.last_flag  = (i == chars.size() - 1) && !abort;
      it.empty_flag = 1'b0;
      byte_feed.push_back(it);
    end
    if (abort || chars.size() == 0) push_empty();
  endfunction

  function automatic void queue_text(input string s);
    logic [7:0] chars[$];
    add_text(chars, s);
    queue_path(chars, 1'b0);
  endfunction

  // Long path of filler bytes ending in the given text, to push offsets past one byte
  function automatic void queue_long(input int unsigned fill, input string tail);
    logic [7:0] chars[$];
    repeat (fill) chars.push_back("a");
    add_text(chars, tail);
    queue_path(chars, 1'b0);
  endfunction

  function automatic logic [7:0] pick_name_char();
    string pool;
    pool = "abcdefghijklmnopqrstuvwxyz0123456789_-.~";
    return pool[$urandom_range(pool.len() - 1)];
  endfunction

  function automatic logic [7:0] pick_bad_char();
    case ($urandom_range(6))
      0: return ChSpace;
      1: return ChAt;
      2: return ChBslash;
      3: return ChColon;
      4: return 8'($urandom_range(31));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Mostly well-formed paths with random content, plus noise and cut-off paths
  function automatic void queue_random_path();
    logic [7:0] chars[$];
    int         kind, segs;
    logic       abort;
    kind  = $urandom_range(99);
    abort = 1'b0;
    if (kind < 4) begin
      push_empty();
    end else if (kind < 14) begin
      repeat ($urandom_range(1, 8)) chars.push_back(8'($urandom_range(255)));
      queue_path(chars, 1'b0);
    end else begin
      case ($urandom_range(11))
        0: add_text(chars, "./");
        1: add_text(chars, "../");
        2: add_text(chars, "/");
        3: add_text(chars, " ");
        4: add_text(chars, ".");
        5: add_text(chars, "..");
        default: ;
      endcase
      segs = $urandom_range(1, 4);
      for (int i = 0; i < segs; i++) begin
        if (i > 0) chars.push_back(ChSlash);
        case ($urandom_range(9))
          0: add_text(chars, "..");
          1: add_text(chars, ".");
          default: repeat ($urandom_range(1, 6)) chars.push_back(pick_name_char());
        endcase
      end
      if ($urandom_range(7) == 0) add_text(chars, "/..");
      if ($urandom_range(4) == 0) chars.insert($urandom_range(chars.size()), pick_bad_char());
      if ($urandom_range(19) == 0) chars.push_back(ChSpace);
      abort = (kind < 17);
      queue_path(chars, abort);
    end
  endfunction

  // Driver: present the next transaction at the falling edge, and set the master-side ready
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (byte_feed.size() > 0 && (calm || $urandom_range(99) >= 15)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= byte_feed[0].path_char;
        s_axis_tlast  <= byte_feed[0].last_flag;
        s_axis_tuser  <= byte_feed[0].empty_flag;
        void'(byte_feed.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= rst_ni && (calm || $urandom_range(99) >= 15);
  end

  // Monitor: predict on accepted input, check accepted verdicts, watch for a hang
  always @(posedge clk_i) begin
    path_item_t it;
    verdict_t   want;
    logic       fire_in, fire_out;
    fire_in  = rst_ni && s_axis_tvalid && s_axis_tready;
    fire_out = rst_ni && m_axis_tvalid && m_axis_tready;
    in_taken <= fire_in;
    cyc_count <= cyc_count + 1;

    if (fire_in) begin
      it.path_char  = s_axis_tdata;
      it.last_flag  = s_axis_tlast;
      it.empty_flag = s_axis_tuser;
      track_path_byte(it);
      items_taken <= items_taken + 1;
    end

    if (fire_out) begin
      if (verdict_q.size() == 0) begin
        note_fail($sformatf("unexpected verdict: error_code %0d error_offset %0d",
                            m_axis_tdata[3:0], m_axis_tdata[19:4]));
      end else begin
        want = verdict_q.pop_front();
        if (m_axis_tdata[3:0] !== want.code)
          note_fail($sformatf("error_code: expected %0d, actual %0d",
                              want.code, m_axis_tdata[3:0]));
        if (m_axis_tdata[19:4] !== want.offset)
          note_fail($sformatf("error_offset: expected %0d, actual %0d",
                              want.offset, m_axis_tdata[19:4]));
        if (m_axis_tdata[23:20] !== 4'd0)
          note_fail($sformatf("tdata pad: expected 0, actual %0d", m_axis_tdata[23:20]));
      end
    end

    if (!rst_ni || fire_in || fire_out) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [7:0] chars[$];
    clear_path_track();

    // Directed: first-byte checks, dot prefixes, forbidden bytes, parent references
    push_empty();
    queue_text(" a");
    queue_text("/a");
    queue_text(".");
    queue_text("..");
    queue_text(".x");
    queue_text("..x");
    queue_text("../a");
    queue_text("a b");
    queue_text("ab ");
    queue_text("a@b");
    queue_text("a\\b");
    queue_text("a:b");
    chars = {8'h61, 8'h00, 8'hFF};
    queue_path(chars, 1'b0);
    queue_text("a/../b");
    queue_text("a/..");
    chars = {8'h61, 8'h62};
    queue_path(chars, 1'b1);

    // Offsets around and beyond one byte on long paths
    queue_long(250, "/../b");
    queue_long(260, "/..");
    queue_long(270, "@");

    while (byte_feed.size() < FeedItems) queue_random_path();
    total_items = byte_feed.size();

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (items_taken != total_items) @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ipv_pkg.sv
sv/import_path_validator_core.sv
tb/sv/testbench.sv
